>>> src/mcud_pkg.sv
`default_nettype none
package mcud_pkg;

    localparam int TERM_W = 64;
    localparam int OUT_W  = 63;
    localparam int DEG_W  = 5;
    localparam int VAR_W  = 7;

    localparam logic [DEG_W-1:0] MAX_DEGREE    = 5'd16;
    localparam logic [VAR_W-1:0] MAX_VARIABLES = 7'd64;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_NVAR   = 2'd1;
    localparam logic [1:0] REG_EXCL   = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

>>> src/monomial_count_up_to_degree.sv
`default_nettype none
// Monomial count up to a degree.
// s_ channel: one item carries a degree; s_tready is high only while the
// block is idle, so items are taken one at a time.
// m_ channel: one item carries the monomial count for that degree.
// APB port: reg 0 square-free mode, reg 1 variable count, reg 2 excluded
// count, at byte addresses 0, 4, 8. Write only while idle.
// A trivial case (degree 0, or no term to iterate) goes from the accepting
// edge straight to the output stage. Otherwise each binomial term takes a
// multiply step, a division of the 64-bit term in the shared radix-2
// divider and an accumulate step when the divider is done; up to 16 terms.
// The next item is taken at the edge at which the previous result can
// first be taken.
// Reset clears the registers to mode 0, variable count 1, excluded 0, and
// drops m_tvalid. A stalled receiver holds the result in the output
// register; the next item may be accepted meanwhile, but its result waits
// until the previous one is taken.
module monomial_count_up_to_degree
    import mcud_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [4:0] degree
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,   // [62:0] monomial_count
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;

    logic [2:0]        state_reg;
    logic              mode_reg;
    logic [VAR_W-1:0]  nvar_reg;
    logic [VAR_W-1:0]  excl_reg;
    logic [DEG_W-1:0]  k_reg;
    logic [DEG_W-1:0]  limit_reg;
    logic [TERM_W-1:0] term_reg;
    logic [TERM_W-1:0] sum_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_valid_reg;

    logic              cfg_wr;
    logic [1:0]        cfg_idx;
    logic [DEG_W-1:0]  d_sat;
    logic [VAR_W-1:0]  n_sat;
    logic [VAR_W-1:0]  m_free;
    logic [DEG_W-1:0]  sf_limit;
    logic [VAR_W:0]    factor_wide;
    logic [VAR_W-1:0]  factor;
    logic [TERM_W+VAR_W-1:0] mul_full;
    logic              div_start;
    logic [TERM_W-1:0] div_quo;
    div_status_t       div_status;
    logic              s_acc;
    logic              out_free;
    logic              out_load;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            nvar_reg <= 7'd1;
            excl_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MODE: mode_reg <= pwdata[0];
                REG_NVAR: nvar_reg <= pwdata[VAR_W-1:0];
                REG_EXCL: excl_reg <= pwdata[VAR_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MODE: prdata = {31'b0, mode_reg};
            REG_NVAR: prdata = {25'b0, nvar_reg};
            REG_EXCL: prdata = {25'b0, excl_reg};
            default:  prdata = '0;
        endcase
    end

    assign d_sat    = (s_tdata[DEG_W-1:0] > MAX_DEGREE) ? MAX_DEGREE : s_tdata[DEG_W-1:0];
    assign n_sat    = (nvar_reg > MAX_VARIABLES) ? MAX_VARIABLES : nvar_reg;
    assign m_free   = (excl_reg > n_sat) ? '0 : (n_sat - excl_reg);
    assign sf_limit = (m_free < {2'b0, d_sat}) ? m_free[DEG_W-1:0] : d_sat;

    // sf: m - k + 1, general: n + k - 1
    assign factor_wide = mode_reg
        ? ({1'b0, m_free} + 8'd1 - {3'b0, k_reg})
        : ({1'b0, n_sat} + {3'b0, k_reg} - 8'd1);
    assign factor   = factor_wide[VAR_W-1:0];
    assign mul_full = term_reg * factor;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign out_load  = (state_reg == ST_DONE) && out_free;
    assign div_start = (state_reg == ST_MUL);

    mcud_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul_full[TERM_W-1:0]),
        .divisor  (k_reg),
        .quotient (div_quo),
        .status   (div_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        if (d_sat == '0) begin
                            state_reg <= ST_DONE;
                        end else if (mode_reg) begin
                            state_reg <= (sf_limit == '0) ? ST_DONE : ST_MUL;
                        end else begin
                            state_reg <= (d_sat < 5'd2) ? ST_DONE : ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_status.done) begin
                        state_reg <= (k_reg == limit_reg) ? ST_DONE : ST_MUL;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (d_sat == '0) begin
                        sum_reg <= '0;
                    end else if (mode_reg) begin
                        term_reg  <= 64'd1;
                        sum_reg   <= '0;
                        k_reg     <= 5'd1;
                        limit_reg <= sf_limit;
                    end else begin
                        term_reg  <= {57'b0, n_sat};
                        sum_reg   <= {57'b0, n_sat};
                        k_reg     <= 5'd2;
                        limit_reg <= d_sat;
                    end
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    term_reg <= div_quo;
                    sum_reg  <= sum_reg + div_quo;
                    k_reg    <= k_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_data_reg <= sum_reg[OUT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

`ifndef SYNTHESIS
    a_start_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    a_k_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (k_reg != '0) && (k_reg <= limit_reg))
        else $error("term index out of range");

    a_idle_no_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_status.busy && !div_status.done)
        else $error("divider active while idle");

    a_done_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("divider result without waiting sequencer");
`endif

endmodule
`default_nettype wire

>>> src/mcud_divider.sv
`default_nettype none
module mcud_divider
    import mcud_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [TERM_W-1:0] dividend,
    input  wire logic [DEG_W-1:0]  divisor,
    output logic      [TERM_W-1:0] quotient,
    output div_status_t            status
);

    localparam int CNT_W = $clog2(TERM_W);

    logic [TERM_W-1:0] quo_reg;
    logic [DEG_W-1:0]  rem_reg;
    logic [DEG_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEG_W:0]    trial;
    logic              fits;
    logic [DEG_W:0]    diff;

    assign trial = {rem_reg, quo_reg[TERM_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TERM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[TERM_W-2:0], fits};
            rem_reg <= fits ? diff[DEG_W-1:0] : trial[DEG_W-1:0];
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire
